// ===== design/clpe_pkg.sv =====
// shared constants, types and codes for the circular list positional engine
package clpe_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = ((CNT_W > 7) ? CNT_W : 7) + 1;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DISPLAY   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_BADPOS = 2'd1,
    STS_EMPTY  = 2'd2,
    STS_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_DELETE,
    CM_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t kind;
    idx_t     k;
    idx_t     last_idx;
    data_t    value;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } state_t;

endpackage

// ===== design/clpe_cell.sv =====
// one list cell: holds the word at its list position and trades with its neighbors
module clpe_cell (
  input  logic                clk,
  input  clpe_pkg::cell_cmd_t cmd,
  input  clpe_pkg::idx_t      idx,
  input  clpe_pkg::data_t     left_d,
  input  clpe_pkg::data_t     right_d,
  input  clpe_pkg::data_t     head_d,
  output clpe_pkg::data_t     q
);

  clpe_pkg::data_t data_r;
  clpe_pkg::data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.kind)
      clpe_pkg::CM_INSERT: begin
        // cells past the insertion point move one place toward the tail
        if (idx > cmd.k) begin
          data_nxt = left_d;
        end else if (idx == cmd.k) begin
          data_nxt = cmd.value;
        end
      end
      clpe_pkg::CM_DELETE: begin
        if (idx >= cmd.k) begin
          data_nxt = right_d;
        end
      end
      clpe_pkg::CM_ROTATE: begin
        // the tail cell closes the ring by taking the head word
        if (idx == cmd.last_idx) begin
          data_nxt = head_d;
        end else begin
          data_nxt = right_d;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== design/clpe_ctrl.sv =====
// operation decoder, element counter and display sequencer
module clpe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_opcode,
  input  logic signed [31:0]  in_value,
  input  logic [6:0]          in_position,
  input  clpe_pkg::data_t     head_d,
  output clpe_pkg::cell_cmd_t cmd,
  output logic                out_strobe,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_element,
  output logic [6:0]          out_count,
  output logic                out_last
);

  clpe_pkg::state_t  state_r, state_nxt;
  clpe_pkg::cnt_t    count_r, count_nxt;
  clpe_pkg::cnt_t    rem_r, rem_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  clpe_pkg::status_t out_status_r, out_status_nxt;
  logic [31:0]       out_element_r, out_element_nxt;
  clpe_pkg::cnt_t    out_count_r;
  logic              out_last_r, out_last_nxt;

  clpe_pkg::op_t                op;
  logic [clpe_pkg::CMP_W-1:0]   pos_w;
  logic [clpe_pkg::CMP_W-1:0]   cnt_w;
  logic                         full;
  logic                         empty;

  assign op    = clpe_pkg::op_t'(in_opcode);
  assign pos_w = clpe_pkg::CMP_W'(in_position);
  assign cnt_w = clpe_pkg::CMP_W'(count_r);
  assign full  = (count_r == clpe_pkg::cnt_t'(clpe_pkg::CAPACITY));
  assign empty = (count_r == '0);
  assign busy  = (state_r == clpe_pkg::ST_SHOW);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      clpe_pkg::ST_IDLE: begin
        if (start && op == clpe_pkg::OP_DISPLAY && !empty) begin
          state_nxt = clpe_pkg::ST_SHOW;
        end
      end
      clpe_pkg::ST_SHOW: begin
        if (rem_r == clpe_pkg::cnt_t'(1)) begin
          state_nxt = clpe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = clpe_pkg::ST_IDLE;
      end
    endcase
  end

  // cell commands and result words
  always_comb begin
    cmd.kind        = clpe_pkg::CM_HOLD;
    cmd.k           = '0;
    cmd.last_idx    = clpe_pkg::idx_t'(count_r - clpe_pkg::cnt_t'(1));
    cmd.value       = clpe_pkg::data_t'($unsigned(in_value));
    count_nxt       = count_r;
    rem_nxt         = rem_r;
    out_strobe_nxt  = 1'b0;
    out_status_nxt  = clpe_pkg::STS_OK;
    out_element_nxt = '0;
    out_last_nxt    = 1'b1;
    unique case (state_r)
      clpe_pkg::ST_IDLE: begin
        if (start) begin
          out_strobe_nxt = 1'b1;
          unique case (op) inside
            clpe_pkg::OP_INS_FIRST, clpe_pkg::OP_INS_LAST: begin
              if (full) begin
                out_status_nxt = clpe_pkg::STS_FULL;
              end else begin
                cmd.kind  = clpe_pkg::CM_INSERT;
                cmd.k     = (op == clpe_pkg::OP_INS_FIRST) ? '0 : clpe_pkg::idx_t'(count_r);
                count_nxt = count_r + clpe_pkg::cnt_t'(1);
              end
            end
            clpe_pkg::OP_INS_AT: begin
              if (pos_w == '0 || pos_w > cnt_w + clpe_pkg::CMP_W'(1)) begin
                out_status_nxt = clpe_pkg::STS_BADPOS;
              end else if (full) begin
                out_status_nxt = clpe_pkg::STS_FULL;
              end else begin
                cmd.kind  = clpe_pkg::CM_INSERT;
                cmd.k     = clpe_pkg::idx_t'(pos_w - clpe_pkg::CMP_W'(1));
                count_nxt = count_r + clpe_pkg::cnt_t'(1);
              end
            end
            clpe_pkg::OP_DEL_FIRST, clpe_pkg::OP_DEL_LAST: begin
              if (empty) begin
                out_status_nxt = clpe_pkg::STS_EMPTY;
              end else begin
                cmd.kind  = clpe_pkg::CM_DELETE;
                cmd.k     = (op == clpe_pkg::OP_DEL_FIRST) ? '0 :
                            clpe_pkg::idx_t'(count_r - clpe_pkg::cnt_t'(1));
                count_nxt = count_r - clpe_pkg::cnt_t'(1);
              end
            end
            clpe_pkg::OP_DEL_AT: begin
              if (pos_w == '0 || pos_w > cnt_w) begin
                out_status_nxt = clpe_pkg::STS_BADPOS;
              end else begin
                cmd.kind  = clpe_pkg::CM_DELETE;
                cmd.k     = clpe_pkg::idx_t'(pos_w - clpe_pkg::CMP_W'(1));
                count_nxt = count_r - clpe_pkg::cnt_t'(1);
              end
            end
            clpe_pkg::OP_DISPLAY: begin
              if (empty) begin
                out_status_nxt = clpe_pkg::STS_EMPTY;
              end else begin
                // elements leave one per cycle from the head cell
                out_strobe_nxt = 1'b0;
                rem_nxt        = count_r;
              end
            end
            default: begin
              out_status_nxt = clpe_pkg::STS_OK;
            end
          endcase
        end
      end
      clpe_pkg::ST_SHOW: begin
        cmd.kind        = clpe_pkg::CM_ROTATE;
        out_strobe_nxt  = 1'b1;
        out_element_nxt = 32'(head_d);
        out_last_nxt    = (rem_r == clpe_pkg::cnt_t'(1));
        rem_nxt         = rem_r - clpe_pkg::cnt_t'(1);
      end
      default: begin
        cmd.kind = clpe_pkg::CM_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= clpe_pkg::ST_IDLE;
      count_r      <= '0;
      rem_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rem_r        <= rem_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_count_r   <= count_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_strobe  = out_strobe_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_count   = 7'(out_count_r);
  assign out_last    = out_last_r;

`ifndef ASSERT_OFF
  a_show_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == clpe_pkg::ST_SHOW |-> (rem_r != '0 && count_r != '0))
    else $error("display running with nothing left to show");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= clpe_pkg::cnt_t'(clpe_pkg::CAPACITY))
    else $error("element count above capacity");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == clpe_pkg::ST_SHOW |-> rem_r <= count_r)
    else $error("display counter above element count");

  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("display burst broken before its final word");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && op != clpe_pkg::OP_DISPLAY |=> out_strobe && out_last)
    else $error("accepted operation gave no result word");
`endif

endmodule

// ===== design/circular_list_positional_engine.sv =====
// top level: operation sequencer driving a row of list cells
// non-display operations: result word in the cycle after accept, one operation per cycle while not busy
// display of n elements: busy while the n elements rotate past the head cell, words appear one
//   per cycle once the state and output registers are passed, set by one ring rotation step of the cell row per cycle
// empty display and every flagged no-op: a single word in the cycle after accept
// reset (synchronous, rst_n low): list empty, no clearing pass, ready next cycle
module circular_list_positional_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_value,
  input  logic [6:0]         in_position,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_element,
  output logic [6:0]         out_count,
  output logic               out_last
);

  clpe_pkg::cell_cmd_t cmd;
  clpe_pkg::data_t     cell_q [clpe_pkg::CAPACITY];

  clpe_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_opcode   (in_opcode),
    .in_value    (in_value),
    .in_position (in_position),
    .head_d      (cell_q[0]),
    .cmd         (cmd),
    .out_strobe  (out_strobe),
    .out_status  (out_status),
    .out_element (out_element),
    .out_count   (out_count),
    .out_last    (out_last)
  );

  for (genvar i = 0; i < clpe_pkg::CAPACITY; i++) begin : g_cell
    clpe_pkg::data_t left_d;
    clpe_pkg::data_t right_d;

    // end cells read zero from the missing neighbor; the first cell never takes it
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = cell_q[i-1];
    end

    if (i == clpe_pkg::CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = cell_q[i+1];
    end

    clpe_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .idx     (clpe_pkg::idx_t'(i)),
      .left_d  (left_d),
      .right_d (right_d),
      .head_d  (cell_q[0]),
      .q       (cell_q[i])
    );
  end

endmodule
